FILE: rtl/ntt_pkg.sv
// Shared types, constants and small arithmetic helpers for the radix-2 NTT block.
// Depends on nothing; ntt_modmul, ntt_front, ntt_back and the top level import it.
package ntt_pkg;

   // Residue width and the fixed prime modulus (119 * 2^23 + 1).
   localparam int CW = 30;
   localparam logic [31:0] MODULUS = 32'd998244353;
   localparam int ROOT_ORDER_LOG = 23;
   localparam int SQW = $clog2(ROOT_ORDER_LOG + 1);

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_FORWARD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_BACKWARD = 2'd3;

   // Configuration handed from the register file to the transform engine.
   typedef struct packed {
      logic inverse;
      logic [CW-1:0] root_fwd;
      logic [CW-1:0] root_bwd;
   } ntt_cfg_type;

   // A 30-bit value is below twice the modulus, so one subtraction reduces it.
   function automatic logic [CW-1:0] reduce_once(input logic [CW-1:0] x);
      logic [CW:0] wide;
      wide = {1'b0, x};
      if (wide >= MODULUS[CW:0]) begin
         wide = wide - MODULUS[CW:0];
      end
      return wide[CW-1:0];
   endfunction

   // Inverse of 2^s modulo the prime: since 2^23 divides MODULUS - 1,
   // it equals MODULUS - (MODULUS - 1) / 2^s.
   function automatic logic [CW-1:0] inv_pow2(input logic [2:0] s);
      logic [31:0] val;
      val = MODULUS - ((MODULUS - 32'd1) >> s);
      return val[CW-1:0];
   endfunction

endpackage

FILE: rtl/ntt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ntt_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ntt_modmul.sv
// Bit-serial modular multiplier: one bit of the second operand per cycle.
// Depends on ntt_pkg for the modulus and residue width.
module ntt_modmul
   import ntt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [CW-1:0] a_in,
   input  logic [CW-1:0] b_in,
   output logic          busy,
   output logic [CW-1:0] product
);

   localparam int CNTW = $clog2(CW);

   logic          busy_ff, busy_in;
   logic [CW-1:0] a_ff, a_in_nx;
   logic [CW-1:0] b_ff, b_in_nx;
   logic [CW-1:0] acc_ff, acc_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [CW:0]   dbl, dbl_red, add, add_red;

   // One step: acc = 2 * acc + bit * a, kept below the modulus.
   always_comb begin
      dbl = {acc_ff, 1'b0};
      dbl_red = (dbl >= MODULUS[CW:0]) ? dbl - MODULUS[CW:0] : dbl;
      add = dbl_red + (b_ff[CW-1] ? {1'b0, a_ff} : '0);
      add_red = (add >= MODULUS[CW:0]) ? add - MODULUS[CW:0] : add;
   end

   // Sequencing of the thirty steps.
   always_comb begin
      busy_in = busy_ff;
      a_in_nx = a_ff;
      b_in_nx = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in_nx = a_in;
         b_in_nx = b_in;
         acc_in = '0;
         cnt_in = CNTW'(CW - 1);
      end else if (busy_ff) begin
         acc_in = add_red[CW-1:0];
         b_in_nx = {b_ff[CW-2:0], 1'b0};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff <= a_in_nx;
      b_ff <= b_in_nx;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign product = acc_ff;

endmodule

FILE: rtl/ntt_queue.sv
// Two-entry queue that decouples the load front end from the transform engine.
// Depends on nothing.
module ntt_queue #(
   parameter int WIDTH = 37
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enq,
   input  logic [WIDTH-1:0] enq_data,
   output logic             full,
   input  logic             deq,
   output logic [WIDTH-1:0] deq_data,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ enq;
      rd_ptr_in = rd_ptr_ff ^ deq;
      count_in = count_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (enq) begin
         slot_ff[wr_ptr_ff] <= enq_data;
      end
   end

   assign full = count_ff[1];
   assign empty = (count_ff == 2'd0);
   assign deq_data = slot_ff[rd_ptr_ff];

endmodule

FILE: rtl/ntt_front.sv
// Load front end: accepts residues, reduces them and tags the one that completes a set.
// Depends on ntt_pkg.
module ntt_front
   import ntt_pkg::*;
#(
   parameter int AW = 6,
   parameter int SW = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [CW-1:0]      req_coefficient_in,
   output logic               req_full,
   input  logic [SW-1:0]      eff_log,
   input  logic               q_full,
   output logic               q_enq,
   output logic [CW+AW:0]     q_data
);

   logic [6:0] load_count_ff, load_count_in;
   logic [7:0] next_count;
   logic [7:0] size_n;
   logic       last;

   // A transaction completes the set when the count reaches the size in use.
   always_comb begin
      next_count = {1'b0, load_count_ff} + 8'd1;
      size_n = 8'd1 << eff_log;
      last = (next_count >= size_n);
      q_enq = req_push && !q_full;
      load_count_in = load_count_ff;
      if (q_enq) begin
         load_count_in = last ? 7'd0 : next_count[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

   assign req_full = q_full;
   assign q_data = {last, load_count_ff[AW-1:0], reduce_once(req_coefficient_in)};

endmodule

FILE: rtl/ntt_back.sv
// Transform engine: stores loaded residues, runs bit reversal, butterflies and scaling,
// and drives the result register. Depends on ntt_pkg, ntt_ram and ntt_modmul.
module ntt_back
   import ntt_pkg::*;
#(
   parameter int AW = 6,
   parameter int SW = 3
) (
   input  logic            clock,
   input  logic            reset,
   input  ntt_cfg_type     cfg,
   input  logic [SW-1:0]   eff_log,
   input  logic            q_empty,
   input  logic [CW+AW:0]  q_data,
   output logic            q_deq,
   input  logic            rsp_pop,
   output logic            rsp_empty,
   output logic [CW-1:0]   rsp_coefficient_out,
   output logic            rsp_last_out
);

   localparam int DEPTH = 2 ** AW;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_COPY_RD = 4'd1;
   localparam logic [3:0] ST_COPY_WR = 4'd2;
   localparam logic [3:0] ST_SQ_GO   = 4'd3;
   localparam logic [3:0] ST_SQ_WAIT = 4'd4;
   localparam logic [3:0] ST_BF_RDU  = 4'd5;
   localparam logic [3:0] ST_BF_RDV  = 4'd6;
   localparam logic [3:0] ST_BF_MUL  = 4'd7;
   localparam logic [3:0] ST_BF_WAIT = 4'd8;
   localparam logic [3:0] ST_BF_WRU  = 4'd9;
   localparam logic [3:0] ST_BF_WRV  = 4'd10;
   localparam logic [3:0] ST_EM_RD   = 4'd11;
   localparam logic [3:0] ST_EM_MUL  = 4'd12;
   localparam logic [3:0] ST_EM_WAIT = 4'd13;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [SW-1:0] st_ff, st_in;
   logic [SQW-1:0] sq_ff, sq_in;
   logic [AW:0]   base_ff, base_in;
   logic [AW-1:0] k_ff, k_in;
   logic [CW-1:0] w_ff, w_in;
   logic [CW-1:0] wlen_ff, wlen_in;
   logic [CW-1:0] u_ff, u_in;
   logic          out_valid_ff, out_valid_in;
   logic [CW-1:0] out_coef_ff, out_coef_in;
   logic          out_last_ff, out_last_in;

   logic [AW:0]   size_n;
   logic [AW-1:0] half;
   logic [AW:0]   len;
   logic [AW-1:0] u_addr, v_addr;
   logic [AW-1:0] k_next;
   logic [AW:0]   base_next;
   logic [CW-1:0] root_red;
   logic [CW-1:0] scale;
   logic [CW:0]   sum_w, diff_w;
   logic [CW-1:0] sum_r, diff_r;
   logic          idx_last;
   logic          out_load;

   logic          x_wr_en, y_wr_en;
   logic [AW-1:0] x_wr_addr, x_rd_addr, y_wr_addr, y_rd_addr;
   logic [CW-1:0] x_wr_data, x_rd_data, y_wr_data, y_rd_data;

   logic          dmul_start, dmul_busy;
   logic [CW-1:0] dmul_a, dmul_b, dmul_p;
   logic          tmul_start, tmul_busy;
   logic [CW-1:0] tmul_a, tmul_b, tmul_p;

   // Reverse the low s bits of an index.
   function automatic logic [AW-1:0] rev_bits(input logic [AW-1:0] v, input logic [SW-1:0] s);
      logic [AW-1:0] r;
      for (int j = 0; j < AW; j++) begin
         r[j] = v[AW-1-j];
      end
      return r >> (SW'(AW) - s);
   endfunction

   // Load buffer, written by incoming transactions, read once by the reorder pass.
   ntt_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_load_ram (
      .clock  (clock),
      .wr_en  (x_wr_en),
      .wr_addr(x_wr_addr),
      .wr_data(x_wr_data),
      .rd_addr(x_rd_addr),
      .rd_data(x_rd_data)
   );

   // Working store holding the reordered data through all stages.
   ntt_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_work_ram (
      .clock  (clock),
      .wr_en  (y_wr_en),
      .wr_addr(y_wr_addr),
      .wr_data(y_wr_data),
      .rd_addr(y_rd_addr),
      .rd_data(y_rd_data)
   );

   // Data multiplier: butterfly products and the final scaling.
   ntt_modmul u_data_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (dmul_start),
      .a_in   (dmul_a),
      .b_in   (dmul_b),
      .busy   (dmul_busy),
      .product(dmul_p)
   );

   // Twiddle multiplier: root squaring and twiddle advance.
   ntt_modmul u_twid_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (tmul_start),
      .a_in   (tmul_a),
      .b_in   (tmul_b),
      .busy   (tmul_busy),
      .product(tmul_p)
   );

   // Geometry of the current stage and the butterfly arithmetic.
   always_comb begin
      size_n = (AW+1)'(1) << eff_log;
      half = AW'(1) << (st_ff - SW'(1));
      len = {half, 1'b0};
      u_addr = base_ff[AW-1:0] + k_ff;
      v_addr = u_addr + half;
      k_next = k_ff + AW'(1);
      base_next = base_ff + len;
      root_red = reduce_once(cfg.inverse ? cfg.root_bwd : cfg.root_fwd);
      scale = cfg.inverse ? inv_pow2(3'(eff_log)) : CW'(1);
      sum_w = {1'b0, u_ff} + {1'b0, dmul_p};
      sum_r = (sum_w >= MODULUS[CW:0]) ? sum_w[CW-1:0] - MODULUS[CW-1:0] : sum_w[CW-1:0];
      diff_w = (u_ff >= dmul_p) ? {1'b0, u_ff - dmul_p}
                                : {1'b0, u_ff} + MODULUS[CW:0] - {1'b0, dmul_p};
      diff_r = diff_w[CW-1:0];
      idx_last = ({1'b0, idx_ff} == size_n - (AW+1)'(1));
   end

   // Main sequencer.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      st_in = st_ff;
      sq_in = sq_ff;
      base_in = base_ff;
      k_in = k_ff;
      w_in = w_ff;
      wlen_in = wlen_ff;
      u_in = u_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_coef_in = out_coef_ff;
      out_last_in = out_last_ff;
      out_load = 1'b0;
      q_deq = 1'b0;
      x_wr_en = 1'b0;
      x_wr_addr = q_data[CW+AW-1:CW];
      x_wr_data = q_data[CW-1:0];
      x_rd_addr = rev_bits(idx_ff, eff_log);
      y_wr_en = 1'b0;
      y_wr_addr = idx_ff;
      y_wr_data = x_rd_data;
      y_rd_addr = idx_ff;
      dmul_start = 1'b0;
      dmul_a = w_ff;
      dmul_b = y_rd_data;
      tmul_start = 1'b0;
      tmul_a = w_ff;
      tmul_b = wlen_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_deq = 1'b1;
               x_wr_en = 1'b1;
               if (q_data[CW+AW]) begin
                  idx_in = '0;
                  state_in = ST_COPY_RD;
               end
            end
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            y_wr_en = 1'b1;
            if (idx_last) begin
               st_in = SW'(1);
               sq_in = SQW'(ROOT_ORDER_LOG - 1);
               wlen_in = root_red;
               state_in = ST_SQ_GO;
            end else begin
               idx_in = idx_ff + AW'(1);
               state_in = ST_COPY_RD;
            end
         end
         ST_SQ_GO: begin
            if (sq_ff == '0) begin
               base_in = '0;
               k_in = '0;
               w_in = CW'(1);
               state_in = ST_BF_RDU;
            end else begin
               tmul_start = 1'b1;
               tmul_a = wlen_ff;
               state_in = ST_SQ_WAIT;
            end
         end
         ST_SQ_WAIT: begin
            if (!tmul_busy) begin
               wlen_in = tmul_p;
               sq_in = sq_ff - SQW'(1);
               state_in = ST_SQ_GO;
            end
         end
         ST_BF_RDU: begin
            y_rd_addr = u_addr;
            state_in = ST_BF_RDV;
         end
         ST_BF_RDV: begin
            y_rd_addr = v_addr;
            u_in = y_rd_data;
            state_in = ST_BF_MUL;
         end
         ST_BF_MUL: begin
            dmul_start = 1'b1;
            tmul_start = 1'b1;
            state_in = ST_BF_WAIT;
         end
         ST_BF_WAIT: begin
            if (!dmul_busy && !tmul_busy) begin
               state_in = ST_BF_WRU;
            end
         end
         ST_BF_WRU: begin
            y_wr_en = 1'b1;
            y_wr_addr = u_addr;
            y_wr_data = sum_r;
            state_in = ST_BF_WRV;
         end
         ST_BF_WRV: begin
            y_wr_en = 1'b1;
            y_wr_addr = v_addr;
            y_wr_data = diff_r;
            if (k_next == half) begin
               k_in = '0;
               w_in = CW'(1);
               if (base_next >= size_n) begin
                  if (st_ff == eff_log) begin
                     idx_in = '0;
                     state_in = ST_EM_RD;
                  end else begin
                     st_in = st_ff + SW'(1);
                     sq_in = SQW'(ROOT_ORDER_LOG) - SQW'(st_ff) - SQW'(1);
                     wlen_in = root_red;
                     state_in = ST_SQ_GO;
                  end
               end else begin
                  base_in = base_next;
                  state_in = ST_BF_RDU;
               end
            end else begin
               k_in = k_next;
               w_in = tmul_p;
               state_in = ST_BF_RDU;
            end
         end
         ST_EM_RD: begin
            state_in = ST_EM_MUL;
         end
         ST_EM_MUL: begin
            dmul_start = 1'b1;
            dmul_a = scale;
            state_in = ST_EM_WAIT;
         end
         ST_EM_WAIT: begin
            if (!dmul_busy && (!out_valid_ff || rsp_pop)) begin
               out_load = 1'b1;
               out_valid_in = 1'b1;
               out_coef_in = dmul_p;
               out_last_in = idx_last;
               if (idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + AW'(1);
                  state_in = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff <= idx_in;
      st_ff <= st_in;
      sq_ff <= sq_in;
      base_ff <= base_in;
      k_ff <= k_in;
      w_ff <= w_in;
      wlen_ff <= wlen_in;
      u_ff <= u_in;
      out_coef_ff <= out_coef_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_coefficient_out = out_coef_ff;
   assign rsp_last_out = out_last_ff;

`ifndef SYNTHESIS
   // A multiplier is never restarted while it is still working.
   assert property (@(posedge clock) disable iff (reset) dmul_start |-> !dmul_busy)
      else $error("data multiplier restarted while busy");
   assert property (@(posedge clock) disable iff (reset) tmul_start |-> !tmul_busy)
      else $error("twiddle multiplier restarted while busy");
   // A new result only overwrites the output register once it has been taken.
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_pop))
      else $error("result register overwritten");
   // The engine only dequeues a transaction that is present.
   assert property (@(posedge clock) disable iff (reset) q_deq |-> !q_empty)
      else $error("dequeue from empty queue");
`endif

endmodule

FILE: rtl/ntt_radix2_transform.sv
// Top level of the radix-2 number theoretic transform modulo 998244353.
// Depends on ntt_pkg, ntt_front, ntt_queue and ntt_back.

// The block takes 2^log_size residues one transaction at a time, and once the set is
// complete it bit-reverses them into a working RAM, runs log_size stages of in-place
// Cooley-Tukey butterflies and then returns the transformed residues in index order,
// last_out marking the final one; inverse mode uses root_backward and scales by 1/n.
// Loading goes at one transaction per cycle while the engine is idle (a two-entry queue
// sits in front of it). The transform itself is paced by the bit-serial modular
// multipliers: a reordering pass, then per stage (23 - stage) squarings of the root
// and n/2 butterflies of one data and one twiddle product each, then one scaling
// product per emitted result. Only after the last result does the engine dequeue again.
// No clearing pass follows reset.
module ntt_radix2_transform
   import ntt_pkg::*;
#(
   parameter int MAX_LOG_SIZE = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [CW-1:0]        req_coefficient_in,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [CW-1:0]        rsp_coefficient_out,
   output logic                 rsp_last_out,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CW-1:0]        csr_data
);

   localparam int AW = MAX_LOG_SIZE;
   localparam int SW = $clog2(MAX_LOG_SIZE + 1);
   localparam int QW = CW + AW + 1;

   logic          inverse_mode_ff;
   logic [2:0]    log_size_ff;
   logic [CW-1:0] root_forward_ff;
   logic [CW-1:0] root_backward_ff;
   logic          csr_write;
   logic [SW-1:0] eff_log;
   ntt_cfg_type   cfg;

   logic          q_enq, q_full, q_deq, q_empty;
   logic [QW-1:0] q_wdata, q_rdata;

   // Configuration registers; every write transaction is taken at once.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_mode_ff <= 1'b0;
         log_size_ff <= 3'd6;
         root_forward_ff <= 30'd15311432;
         root_backward_ff <= 30'd469870224;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_INVERSE_MODE:  inverse_mode_ff <= csr_data[0];
            CSR_LOG_SIZE:      log_size_ff <= csr_data[2:0];
            CSR_ROOT_FORWARD:  root_forward_ff <= csr_data;
            CSR_ROOT_BACKWARD: root_backward_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamp the size to the supported range.
   always_comb begin
      if (log_size_ff == 3'd0) begin
         eff_log = SW'(1);
      end else if (log_size_ff > 3'(MAX_LOG_SIZE)) begin
         eff_log = SW'(MAX_LOG_SIZE);
      end else begin
         eff_log = SW'(log_size_ff);
      end
      cfg.inverse = inverse_mode_ff;
      cfg.root_fwd = root_forward_ff;
      cfg.root_bwd = root_backward_ff;
   end

   ntt_front #(.AW(AW), .SW(SW)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_coefficient_in(req_coefficient_in),
      .req_full          (req_full),
      .eff_log           (eff_log),
      .q_full            (q_full),
      .q_enq             (q_enq),
      .q_data            (q_wdata)
   );

   ntt_queue #(.WIDTH(QW)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .enq     (q_enq),
      .enq_data(q_wdata),
      .full    (q_full),
      .deq     (q_deq),
      .deq_data(q_rdata),
      .empty   (q_empty)
   );

   ntt_back #(.AW(AW), .SW(SW)) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .eff_log            (eff_log),
      .q_empty            (q_empty),
      .q_data             (q_rdata),
      .q_deq              (q_deq),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_coefficient_out(rsp_coefficient_out),
      .rsp_last_out       (rsp_last_out)
   );

endmodule
